[rtl/core/evpc_pkg.sv]
// shared types and constants of the encoder velocity p-controller
`default_nettype none

package evpc_pkg;

	// item kinds carried in tuser
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd1;

	localparam int TICK_FIFO_DEPTH = 2;
	localparam int DIV_STEPS       = 24;
	localparam int CMD_LIMIT       = 16711680;

	localparam logic signed [23:0] SPEED_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SPEED_MIN = 24'sh800000;

	// one control tick as handed from front to back
	typedef struct packed {
		logic signed [15:0] count;
		logic        [23:0] elapsed;
		logic signed [23:0] setpoint;
	} tick_t;

	// one result word
	typedef struct packed {
		logic signed [23:0] speed_estimate;
		logic signed [24:0] drive_command;
		logic        [7:0]  rev_duty;
		logic        [7:0]  fwd_duty;
	} result_t;

endpackage

`default_nettype wire

[rtl/core/evpc_front.sv]
// front end: takes input words, counts encoder edges, queues control ticks
`default_nettype none

module evpc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           in_cmd,
	input  wire logic           in_encoder_b,
	input  wire logic [23:0]    in_elapsed,
	input  wire logic [23:0]    in_setpoint,
	output logic                push_valid,
	input  wire logic           push_ready,
	output evpc_pkg::tick_t     push_data
);
	import evpc_pkg::*;

	logic signed [15:0] count_q;
	logic               accept;

	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = accept && (in_cmd == CMD_TICK);

	always_comb begin
		push_data.count    = count_q;
		// zero elapsed time counts as one microsecond
		push_data.elapsed  = (in_elapsed == 24'd0) ? 24'd1 : in_elapsed;
		push_data.setpoint = $signed(in_setpoint);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (in_cmd == CMD_TICK) begin
				count_q <= '0;
			end else if (in_encoder_b) begin
				count_q <= count_q + 16'sd1;
			end else begin
				count_q <= count_q - 16'sd1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/evpc_fifo.sv]
// short tick queue between front and back
`default_nettype none

module evpc_fifo #(
	parameter int DEPTH = evpc_pkg::TICK_FIFO_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire evpc_pkg::tick_t push_data,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output evpc_pkg::tick_t     pop_data
);
	import evpc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tick_t              entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = fill_q < CNT_W'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/evpc_back.sv]
// back end: speed division, proportional update and output register
`default_nettype none

module evpc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire evpc_pkg::tick_t pop_data,
	input  wire logic [31:0]     speed_scale,
	input  wire logic [23:0]     prop_gain,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output evpc_pkg::result_t    out_data
);
	import evpc_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic signed [41:0] LIMIT_POS = 42'(CMD_LIMIT);
	localparam logic signed [41:0] LIMIT_NEG = -42'(CMD_LIMIT);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_CHK, ST_DIV, ST_ERR, ST_GAIN, ST_ACC, ST_OUT
	} state_t;

	state_t             state_q;
	tick_t              tick_q;
	logic               neg_q;
	logic               sat_q;
	logic [47:0]        prod_q;
	logic [23:0]        rem_q;
	logic [23:0]        quo_q;
	logic [STEP_W-1:0]  step_q;
	logic signed [23:0] speed_q;
	logic               err_neg_q;
	logic [23:0]        err_mag_q;
	logic [39:0]        step_mag_q;
	logic signed [24:0] acc_q;
	logic               out_valid_q;
	result_t            out_q;

	logic [15:0]        cnt_mag;
	logic [24:0]        trial;
	logic [24:0]        trial_diff;
	logic               trial_ge;
	logic signed [23:0] speed_c;
	logic signed [24:0] err_c;
	logic [24:0]        err_neg_c;
	logic [47:0]        gprod_c;
	logic signed [41:0] nc_c;
	logic signed [24:0] clamp_c;
	logic [24:0]        acc_neg_c;
	logic               out_free;

	assign pop_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cnt_mag    = tick_q.count[15] ? 16'(-tick_q.count) : tick_q.count;
		// restoring division, one quotient bit per cycle
		trial      = {rem_q, quo_q[23]};
		trial_diff = trial - {1'b0, tick_q.elapsed};
		trial_ge   = trial >= {1'b0, tick_q.elapsed};
		if (neg_q) begin
			speed_c = (sat_q || quo_q > 24'd8388608) ? SPEED_MIN : $signed(24'd0 - quo_q);
		end else begin
			speed_c = (sat_q || quo_q[23]) ? SPEED_MAX : $signed(quo_q);
		end
		err_c     = {tick_q.setpoint[23], tick_q.setpoint} - {speed_c[23], speed_c};
		err_neg_c = 25'(-err_c);
		gprod_c   = {24'd0, prop_gain} * {24'd0, err_mag_q};
		if (err_neg_q) begin
			nc_c = {{17{acc_q[24]}}, acc_q} - $signed({2'b00, step_mag_q});
		end else begin
			nc_c = {{17{acc_q[24]}}, acc_q} + $signed({2'b00, step_mag_q});
		end
		if (nc_c > LIMIT_POS) begin
			clamp_c = 25'(LIMIT_POS);
		end else if (nc_c < LIMIT_NEG) begin
			clamp_c = 25'(LIMIT_NEG);
		end else begin
			clamp_c = nc_c[24:0];
		end
		acc_neg_c = 25'(-acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			neg_q       <= 1'b0;
			sat_q       <= 1'b0;
			prod_q      <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			speed_q     <= '0;
			err_neg_q   <= 1'b0;
			err_mag_q   <= '0;
			step_mag_q  <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						tick_q  <= pop_data;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= {16'd0, cnt_mag} * {16'd0, speed_scale};
					neg_q   <= tick_q.count[15];
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// quotient of 2^24 or more saturates anyway
					step_q <= '0;
					if (prod_q >= {tick_q.elapsed, 24'd0}) begin
						sat_q   <= 1'b1;
						state_q <= ST_ERR;
					end else begin
						sat_q   <= 1'b0;
						rem_q   <= prod_q[47:24];
						quo_q   <= prod_q[23:0];
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= trial_ge ? trial_diff[23:0] : trial[23:0];
					quo_q  <= {quo_q[22:0], trial_ge};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					speed_q   <= speed_c;
					err_neg_q <= err_c[24];
					err_mag_q <= err_c[24] ? err_neg_c[23:0] : err_c[23:0];
					state_q   <= ST_GAIN;
				end
				ST_GAIN: begin
					step_mag_q <= gprod_c[47:8];
					state_q    <= ST_ACC;
				end
				ST_ACC: begin
					acc_q   <= clamp_c;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_q.speed_estimate <= speed_q;
						out_q.drive_command  <= acc_q;
						if (acc_q > 25'sd0) begin
							out_q.fwd_duty <= acc_q[23:16];
							out_q.rev_duty <= 8'd0;
						end else begin
							out_q.fwd_duty <= 8'd0;
							out_q.rev_duty <= acc_neg_c[23:16];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/encoder_velocity_incremental_p_control_unit.sv]
// top level of the encoder velocity incremental p-controller
//
// channel   | direction | handshake                      | contents
// ----------+-----------+--------------------------------+--------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | encoder edge or control tick
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | duties, command, speed estimate
// cfg       | in        | cfg_valid / cfg_ready          | speed_scale, prop_gain writes
//
// an encoder edge word only moves the edge counter
// a control tick is queued; the back end then takes it through these steps
// (pop, multiply, range check, 24 restoring division steps, error, gain, add, output),
// and skips the division steps when the quotient saturates
// s_axis_tready drops only while the tick queue is full; m_axis stalls back up into it
// reset clears counter, stored command, queue and registers; no clearing pass
`default_nettype none

module encoder_velocity_incremental_p_control_unit #(
	parameter int TICK_FIFO_DEPTH = evpc_pkg::TICK_FIFO_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [55:0]                    s_axis_tdata,  // encoder_b, elapsed_us, setpoint
	input  wire logic [0:0]                     s_axis_tuser,  // cmd
	// result stream
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [71:0]                         m_axis_tdata,  // fwd_duty, rev_duty,
	                                                           // drive_command, speed_estimate
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [evpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import evpc_pkg::*;

	logic [31:0] speed_scale_q;
	logic [23:0] prop_gain_q;

	logic    push_valid;
	logic    push_ready;
	tick_t   push_data;
	logic    pop_valid;
	logic    pop_ready;
	tick_t   pop_data;
	result_t result;

	// configuration is always taken; writes beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q <= '0;
			prop_gain_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPEED_SCALE: speed_scale_q <= cfg_data;
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	// front: edge counting and tick capture
	evpc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_cmd       (s_axis_tuser[0]),
		.in_encoder_b (s_axis_tdata[0]),
		.in_elapsed   (s_axis_tdata[24:1]),
		.in_setpoint  (s_axis_tdata[48:25]),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	// tick queue lets edges keep arriving while the back end divides
	evpc_fifo #(
		.DEPTH (TICK_FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: speed estimate, error, command update, output register
	evpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.speed_scale (speed_scale_q),
		.prop_gain   (prop_gain_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (result)
	);

	assign m_axis_tdata = {7'd0, result.speed_estimate, result.drive_command,
		result.rev_duty, result.fwd_duty};

	// command never leaves the clamp range
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[40:16]) <= 25'sd16711680 &&
			$signed(m_axis_tdata[40:16]) >= -25'sd16711680))
		else $error("drive command outside clamp range");

	// forward and reverse drive are never both on
	a_duty_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0))
		else $error("forward and reverse duty both nonzero");

	// forward duty is the integer part of a non-negative command
	a_fwd_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[40]) |-> (m_axis_tdata[7:0] == m_axis_tdata[39:32]))
		else $error("forward duty does not match command");

	// the queue only fills on a queued tick
	a_fill_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tuser[0]))
		else $error("input stalled without a tick being queued");

endmodule

`default_nettype wire
